>>> rtl/plq_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the positional list queue.
// No dependencies; every other file refers to this package by scoped names.

package plq_pkg;

    localparam int DEPTH      = 256;
    localparam int CNT_W      = 9;
    localparam int VAL_W      = 32;
    localparam int SCAN_W     = 16;
    localparam int SCAN_IDX_W = $clog2(SCAN_W);

    typedef enum logic [2:0] {
        KIND_APPEND = 3'd0,
        KIND_REMOVE = 3'd1,
        KIND_INSERT = 3'd2,
        KIND_DELETE = 3'd3,
        KIND_SEARCH = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } cell_cmd_t;

    typedef struct packed {
        logic             hit;
        logic             last;
        logic [CNT_W-1:0] pos;
    } scan_res_t;

endpackage

>>> rtl/positional_list_queue.sv
`timescale 1ns / 1ps
// Top level of the positional list queue: control, chain of storage cells and search scanner.
// Depends on plq_pkg, plq_cell and plq_scan.
//
//  Channel   Direction  Handshake          Contents
//  s_axis    in         s_tvalid/s_tready  request item: kind, value, position, run_length
//  m_axis    out        m_tvalid/m_tready  result item: status, found, match position, head, count
//
// Append, remove, insert, ignored kinds and rejected requests pass from idle straight to completion.
// A delete run makes one chain shift per removed entry before completion.
// A search scans 16-entry chunks in turn (at least one chunk),
// stopping at the chunk with the first match; the chunk width is set by plq_pkg::SCAN_W.
// Reset clears the occupancy and control; entry contents need no clearing.
// A new item is taken while an earlier result still waits in the output register.

module positional_list_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // value[31:0], position[40:32], run_length[49:41], zero pad
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // found[0], match_position[9:1], head_value[41:10],
                                   // occupancy[50:42], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int DEPTH = plq_pkg::DEPTH;
    localparam int CNT_W = plq_pkg::CNT_W;
    localparam int VAL_W = plq_pkg::VAL_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEL,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [CNT_W-1:0]        p0_reg, p0_next;
    logic [CNT_W-1:0]        rem_reg, rem_next;
    plq_pkg::status_t        status_reg, status_next;
    logic                    found_reg, found_next;
    logic [CNT_W-1:0]        mpos_reg, mpos_next;
    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              out_status_reg, out_status_next;
    logic                    out_found_reg, out_found_next;
    logic [CNT_W-1:0]        out_mpos_reg, out_mpos_next;
    logic signed [VAL_W-1:0] out_head_reg, out_head_next;
    logic [CNT_W-1:0]        out_occ_reg, out_occ_next;

    plq_pkg::kind_t          kind;
    logic signed [VAL_W-1:0] in_value;
    logic [CNT_W-1:0]        in_pos;
    logic [CNT_W-1:0]        in_run;
    logic [CNT_W-1:0]        p0;
    logic [CNT_W-1:0]        avail;
    logic [CNT_W-1:0]        del_n;
    logic                    accept;
    logic                    out_free;
    logic                    is_full;
    logic                    is_empty;

    logic                    ld_en;
    logic [CNT_W-1:0]        ld_idx;
    logic                    left_en;
    logic                    right_en;
    logic [CNT_W-1:0]        right_idx;
    logic                    scan_load;
    logic                    scan_step;
    plq_pkg::scan_res_t      sres;

    logic signed [VAL_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]        cell_match;
    logic [DEPTH-1:0]        flags;

    assign kind     = plq_pkg::kind_t'(s_tuser);
    assign in_value = s_tdata[31:0];
    assign in_pos   = s_tdata[40:32];
    assign in_run   = s_tdata[49:41];
    assign p0       = in_pos - CNT_W'(1);
    assign avail    = fill_reg - p0;
    assign del_n    = (in_run < avail) ? in_run : avail;
    assign is_full  = (fill_reg >= DEPTH_C);
    assign is_empty = (fill_reg == '0);

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            localparam logic [CNT_W-1:0] CELL_IDX = CNT_W'(gi);
            plq_pkg::cell_cmd_t      cmd;
            logic signed [VAL_W-1:0] left_d;
            logic signed [VAL_W-1:0] right_d;

            always_comb
            begin
                if (ld_en && (CELL_IDX == ld_idx))
                begin
                    cmd = plq_pkg::CELL_LOAD;
                end
                else if (left_en && (CELL_IDX > ld_idx))
                begin
                    cmd = plq_pkg::CELL_FROM_LEFT;
                end
                else if (right_en && (CELL_IDX >= right_idx))
                begin
                    cmd = plq_pkg::CELL_FROM_RIGHT;
                end
                else
                begin
                    cmd = plq_pkg::CELL_HOLD;
                end
            end

            if (gi == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[gi+1];
            end

            plq_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .load_value (in_value),
                .left_data  (left_d),
                .right_data (right_d),
                .key        (in_value),
                .data       (cell_data[gi]),
                .match      (cell_match[gi])
            );

            assign flags[gi] = cell_match[gi] && (CELL_IDX < fill_reg);
        end
    endgenerate

    plq_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (scan_load),
        .step     (scan_step),
        .flags_in (flags),
        .fill     (fill_reg),
        .res      (sres)
    );

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        p0_next         = p0_reg;
        rem_next        = rem_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        mpos_next       = mpos_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_mpos_next   = out_mpos_reg;
        out_head_next   = out_head_reg;
        out_occ_next    = out_occ_reg;
        ld_en           = 1'b0;
        ld_idx          = p0;
        left_en         = 1'b0;
        right_en        = 1'b0;
        right_idx       = p0_reg;
        scan_load       = 1'b0;
        scan_step       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = plq_pkg::ST_OK;
                    found_next  = 1'b0;
                    mpos_next   = '0;
                    state_next  = S_DONE;
                    unique case (kind)
                        plq_pkg::KIND_APPEND:
                        begin
                            if (is_full)
                            begin
                                status_next = plq_pkg::ST_FULL;
                            end
                            else
                            begin
                                ld_en     = 1'b1;
                                ld_idx    = fill_reg;
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        plq_pkg::KIND_REMOVE:
                        begin
                            if (is_empty)
                            begin
                                status_next = plq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                right_en  = 1'b1;
                                right_idx = '0;
                                fill_next = fill_reg - CNT_W'(1);
                            end
                        end
                        plq_pkg::KIND_INSERT:
                        begin
                            if (is_full)
                            begin
                                status_next = plq_pkg::ST_FULL;
                            end
                            else if ((in_pos == '0) ||
                                     ({1'b0, in_pos} > ({1'b0, fill_reg} + (CNT_W + 1)'(1))))
                            begin
                                status_next = plq_pkg::ST_RANGE;
                            end
                            else
                            begin
                                ld_en     = 1'b1;
                                left_en   = 1'b1;
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        plq_pkg::KIND_DELETE:
                        begin
                            if (is_empty)
                            begin
                                status_next = plq_pkg::ST_EMPTY;
                            end
                            else if ((in_pos == '0) || (in_pos > fill_reg))
                            begin
                                status_next = plq_pkg::ST_RANGE;
                            end
                            else
                            begin
                                p0_next  = p0;
                                rem_next = del_n;
                                if (del_n != '0)
                                begin
                                    state_next = S_DEL;
                                end
                            end
                        end
                        plq_pkg::KIND_SEARCH:
                        begin
                            scan_load  = 1'b1;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DEL:
            begin
                right_en  = 1'b1;
                fill_next = fill_reg - CNT_W'(1);
                rem_next  = rem_reg - CNT_W'(1);
                if (rem_reg == CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (sres.hit)
                begin
                    found_next = 1'b1;
                    mpos_next  = sres.pos;
                    state_next = S_DONE;
                end
                else if (sres.last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    scan_step = 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_found_next  = found_reg;
                    out_mpos_next   = mpos_reg;
                    out_head_next   = is_empty ? '0 : cell_data[0];
                    out_occ_next    = fill_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            p0_reg         <= '0;
            rem_reg        <= '0;
            status_reg     <= plq_pkg::ST_OK;
            found_reg      <= 1'b0;
            mpos_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_found_reg  <= 1'b0;
            out_mpos_reg   <= '0;
            out_head_reg   <= '0;
            out_occ_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            p0_reg         <= p0_next;
            rem_reg        <= rem_next;
            status_reg     <= status_next;
            found_reg      <= found_next;
            mpos_reg       <= mpos_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_found_reg  <= out_found_next;
            out_mpos_reg   <= out_mpos_next;
            out_head_reg   <= out_head_next;
            out_occ_reg    <= out_occ_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {5'd0, out_occ_reg, out_head_reg, out_mpos_reg, out_found_reg};

    a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_C)
        else $error("occupancy exceeds the store depth");

    a_del_shrinks : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEL) |=> (fill_reg == $past(fill_reg) - CNT_W'(1)))
        else $error("delete run step did not remove one entry");

    a_scan_keeps : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |=> $stable(fill_reg))
        else $error("search changed the occupancy");

    a_result_src : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result item raised outside of completion");

endmodule

>>> rtl/plq_cell.sv
`timescale 1ns / 1ps
// One storage cell of the queue chain: holds one entry, loads, or shifts from a neighbor.
// Depends on plq_pkg.

module plq_cell (
    input  logic                              clk,
    input  plq_pkg::cell_cmd_t                cmd,
    input  logic signed [plq_pkg::VAL_W-1:0]  load_value,
    input  logic signed [plq_pkg::VAL_W-1:0]  left_data,
    input  logic signed [plq_pkg::VAL_W-1:0]  right_data,
    input  logic signed [plq_pkg::VAL_W-1:0]  key,
    output logic signed [plq_pkg::VAL_W-1:0]  data,
    output logic                              match
);

    logic signed [plq_pkg::VAL_W-1:0] data_reg;
    logic signed [plq_pkg::VAL_W-1:0] data_next;

    always_comb
    begin
        case (cmd)
            plq_pkg::CELL_LOAD:       data_next = load_value;
            plq_pkg::CELL_FROM_LEFT:  data_next = left_data;
            plq_pkg::CELL_FROM_RIGHT: data_next = right_data;
            default:                  data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == key);

endmodule

>>> rtl/plq_scan.sv
`timescale 1ns / 1ps
// Search scanner: holds the match flags of all cells and walks them one chunk per cycle while step is high.
// Depends on plq_pkg.

module plq_scan (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic                              step,
    input  logic [plq_pkg::DEPTH-1:0]         flags_in,
    input  logic [plq_pkg::CNT_W-1:0]         fill,
    output plq_pkg::scan_res_t                res
);

    localparam int DEPTH      = plq_pkg::DEPTH;
    localparam int CNT_W      = plq_pkg::CNT_W;
    localparam int SCAN_W     = plq_pkg::SCAN_W;
    localparam int SCAN_IDX_W = plq_pkg::SCAN_IDX_W;
    localparam logic [CNT_W:0] STEP_C = (CNT_W + 1)'(SCAN_W);

    logic [DEPTH-1:0]      flags_reg;
    logic [DEPTH-1:0]      flags_next;
    logic [CNT_W-1:0]      base_reg;
    logic [CNT_W-1:0]      base_next;
    logic [SCAN_W-1:0]     chunk;
    logic [SCAN_IDX_W-1:0] pe;
    logic [CNT_W:0]        pos_sum;

    assign chunk = flags_reg[SCAN_W-1:0];

    always_comb
    begin
        pe = '0;
        for (int k = SCAN_W - 1; k >= 0; k--)
        begin
            if (chunk[k])
            begin
                pe = SCAN_IDX_W'(k);
            end
        end
    end

    assign pos_sum  = {1'b0, base_reg} + (CNT_W + 1)'(pe) + (CNT_W + 1)'(1);
    assign res.hit  = |chunk;
    assign res.last = (({1'b0, base_reg} + STEP_C) >= {1'b0, fill});
    assign res.pos  = pos_sum[CNT_W-1:0];

    always_comb
    begin
        flags_next = flags_reg;
        base_next  = base_reg;
        if (load)
        begin
            flags_next = flags_in;
            base_next  = '0;
        end
        else if (step)
        begin
            flags_next = {{SCAN_W{1'b0}}, flags_reg[DEPTH-1:SCAN_W]};
            base_next  = base_reg + CNT_W'(SCAN_W);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            base_reg  <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
            base_reg  <= base_next;
        end
    end

endmodule

>>> sim/tb_positional_list_queue.sv
`timescale 1ns / 1ps
// Self-checking testbench for positional_list_queue: directed rows, a fill to capacity and
// random requests under several idle and stall patterns, each result checked against a model or a typed expectation.
// Depends on plq_pkg and the positional_list_queue RTL.

module tb_positional_list_queue;

    localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
    localparam logic [2:0] KIND_SPARE_MID = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI  = 3'd7;
    localparam int         DRAIN_CYCLES   = 300;
    localparam int         LONG_HOLD      = 400;
    localparam int         PHASE_ITEMS    = 170;
    localparam int         MAX_PRINTS     = 40;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] value;
        logic [8:0]  pos;
        logic [8:0]  run;
    } request_t;

    typedef struct {
        logic [1:0]  status;
        logic        found;
        logic [8:0]  match_pos;
        logic [31:0] head;
        logic [8:0]  occ;
    } outcome_t;

    typedef struct {
        request_t req;
        bit       typed;
        outcome_t res;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    logic [31:0] list_entries [plq_pkg::DEPTH];
    int          list_fill;
    outcome_t    pending_outcomes [$];
    dir_row_t    dir_rows [$];

    int error_count;
    int checked_count;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req;
    int kind_seen [8];
    int full_seen;
    int found_seen;
    int peak_fill;

    positional_list_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        if (error_count < MAX_PRINTS)
            $display("ERROR at %0t, result %0d: %s got %0h expected %0h",
                     $realtime, checked_count, what, got, want);
        error_count++;
    endtask

    task list_step(input request_t r, output outcome_t o);
        int i;
        int start;
        int n;
        o.status    = plq_pkg::ST_OK;
        o.found     = 1'b0;
        o.match_pos = '0;
        case (r.kind)
            plq_pkg::KIND_APPEND:
                if (list_fill >= plq_pkg::DEPTH)
                    o.status = plq_pkg::ST_FULL;
                else
                begin
                    list_entries[list_fill] = r.value;
                    list_fill++;
                end
            plq_pkg::KIND_REMOVE:
                if (list_fill == 0)
                    o.status = plq_pkg::ST_EMPTY;
                else
                begin
                    for (i = 1; i < list_fill; i++)
                        list_entries[i-1] = list_entries[i];
                    list_fill--;
                end
            plq_pkg::KIND_INSERT:
                if (list_fill >= plq_pkg::DEPTH)
                    o.status = plq_pkg::ST_FULL;
                else if (r.pos == 0 || int'(r.pos) > list_fill + 1)
                    o.status = plq_pkg::ST_RANGE;
                else
                begin
                    for (i = list_fill; i >= int'(r.pos); i--)
                        list_entries[i] = list_entries[i-1];
                    list_entries[r.pos-1] = r.value;
                    list_fill++;
                end
            plq_pkg::KIND_DELETE:
                if (list_fill == 0)
                    o.status = plq_pkg::ST_EMPTY;
                else if (r.pos == 0 || int'(r.pos) > list_fill)
                    o.status = plq_pkg::ST_RANGE;
                else
                begin
                    start = int'(r.pos) - 1;
                    n = (int'(r.run) < list_fill - start) ? int'(r.run) : list_fill - start;
                    for (i = start + n; i < list_fill; i++)
                        list_entries[i-n] = list_entries[i];
                    list_fill -= n;
                end
            plq_pkg::KIND_SEARCH:
                for (i = 0; i < list_fill; i++)
                    if (!o.found && list_entries[i] == r.value)
                    begin
                        o.found     = 1'b1;
                        o.match_pos = 9'(i + 1);
                    end
            default:
                ;
        endcase
        o.head = (list_fill > 0) ? list_entries[0] : 32'd0;
        o.occ  = 9'(list_fill);
    endtask

    task add_row(input logic [2:0] kind, input logic [31:0] value, input int pos, input int run,
                 input bit typed, input logic [1:0] status, input int occ,
                 input logic [31:0] head);
        dir_row_t row;
        row.req.kind      = kind;
        row.req.value     = value;
        row.req.pos       = 9'(pos);
        row.req.run       = 9'(run);
        row.typed         = typed;
        row.res.status    = status;
        row.res.found     = 1'b0;
        row.res.match_pos = '0;
        row.res.occ       = 9'(occ);
        row.res.head      = head;
        dir_rows.push_back(row);
    endtask

    // Entered and left at a falling edge; the predictor runs when the item is taken.
    task send_item(input request_t r, input bit typed, input outcome_t typed_res);
        outcome_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = r.kind;
        s_tdata  = {6'd0, r.run, r.pos, r.value};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        list_step(r, predicted);
        kind_seen[r.kind]++;
        if (predicted.status == plq_pkg::ST_FULL)
            full_seen++;
        if (predicted.found)
            found_seen++;
        if (list_fill > peak_fill)
            peak_fill = list_fill;
        pending_outcomes.push_back(typed ? typed_res : predicted);
        @(negedge clk);
    endtask

    task send_plain(input logic [2:0] kind, input logic [31:0] value, input int pos,
                    input int run);
        request_t r;
        outcome_t none;
        r.kind  = kind;
        r.value = value;
        r.pos   = 9'(pos);
        r.run   = 9'(run);
        none    = '{default: '0};
        send_item(r, 1'b0, none);
    endtask

    task wait_all_results;
        s_tvalid = 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge clk);
    endtask

    function automatic request_t pick_request(input bit grow);
        request_t r;
        int roll;
        roll = $urandom_range(99);
        if (grow)
            r.kind = (roll < 35) ? plq_pkg::KIND_APPEND : (roll < 60) ? plq_pkg::KIND_INSERT :
                     (roll < 70) ? plq_pkg::KIND_REMOVE : (roll < 80) ? plq_pkg::KIND_DELETE :
                     (roll < 95) ? plq_pkg::KIND_SEARCH :
                     3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
        else
            r.kind = (roll < 10) ? plq_pkg::KIND_APPEND : (roll < 20) ? plq_pkg::KIND_INSERT :
                     (roll < 45) ? plq_pkg::KIND_REMOVE : (roll < 75) ? plq_pkg::KIND_DELETE :
                     (roll < 95) ? plq_pkg::KIND_SEARCH :
                     3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
        roll = $urandom_range(99);
        if (roll < 50)
            r.value = $urandom;
        else if (roll < 80 && list_fill > 0)
            r.value = list_entries[$urandom_range(list_fill - 1, 0)];
        else
            case ($urandom_range(4))
                0:       r.value = 32'h0000_0000;
                1:       r.value = 32'hFFFF_FFFF;
                2:       r.value = 32'h8000_0000;
                3:       r.value = 32'h7FFF_FFFF;
                default: r.value = 32'($urandom_range(7));
            endcase
        if ($urandom_range(99) < 85)
            r.pos = (r.kind == plq_pkg::KIND_INSERT) ? 9'($urandom_range(list_fill + 1, 1)) :
                    (list_fill == 0) ? 9'd1 : 9'($urandom_range(list_fill, 1));
        else
            r.pos = 9'($urandom_range(511));
        roll = $urandom_range(99);
        r.run = (roll < 80) ? 9'($urandom_range(4, 1)) :
                (roll < 92) ? 9'($urandom_range(16)) : 9'($urandom_range(511));
        return r;
    endfunction

    initial
    begin
        int hold_left;
        bit hold_taken;
        m_tready   = 1'b0;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_left  = LONG_HOLD;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else
                m_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_outcomes.size() == 0)
                report_mismatch("result with nothing expected", m_tdata[31:0], 32'd0);
            else
            begin
                want = pending_outcomes.pop_front();
                if (m_tuser != want.status)
                    report_mismatch("status", 32'(m_tuser), 32'(want.status));
                if (m_tdata[0] != want.found)
                    report_mismatch("found", 32'(m_tdata[0]), 32'(want.found));
                if (m_tdata[9:1] != want.match_pos)
                    report_mismatch("match_position", 32'(m_tdata[9:1]), 32'(want.match_pos));
                if (m_tdata[41:10] != want.head)
                    report_mismatch("head_value", m_tdata[41:10], want.head);
                if (m_tdata[50:42] != want.occ)
                    report_mismatch("occupancy", 32'(m_tdata[50:42]), 32'(want.occ));
            end
            checked_count++;
        end
    end

    initial
    begin
        bit grow;
        request_t r;
        int phase;
        int n;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        rst_n          = 1'b0;
        error_count    = 0;
        checked_count  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        full_seen      = 0;
        found_seen     = 0;
        peak_fill      = 0;
        list_fill      = 0;
        grow           = 1'b1;
        foreach (kind_seen[k])
            kind_seen[k] = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        add_row(plq_pkg::KIND_REMOVE, 32'd0, 1, 1, 1, plq_pkg::ST_EMPTY, 0, 32'd0);
        add_row(plq_pkg::KIND_DELETE, 32'd0, 1, 1, 1, plq_pkg::ST_EMPTY, 0, 32'd0);
        add_row(plq_pkg::KIND_SEARCH, 32'd0, 1, 1, 1, plq_pkg::ST_OK,    0, 32'd0);
        add_row(plq_pkg::KIND_INSERT, 32'd5, 0, 1, 1, plq_pkg::ST_RANGE, 0, 32'd0);
        add_row(plq_pkg::KIND_INSERT, 32'd5, 2, 1, 1, plq_pkg::ST_RANGE, 0, 32'd0);
        add_row(plq_pkg::KIND_APPEND, 32'h7FFF_FFFF, 1, 1, 1, plq_pkg::ST_OK, 1, 32'h7FFF_FFFF);
        add_row(plq_pkg::KIND_APPEND, 32'h8000_0000, 1, 1, 1, plq_pkg::ST_OK, 2, 32'h7FFF_FFFF);
        add_row(plq_pkg::KIND_INSERT, 32'hFFFF_FFFF, 1, 1, 1, plq_pkg::ST_OK, 3, 32'hFFFF_FFFF);
        add_row(plq_pkg::KIND_INSERT, 32'd0,         4, 1, 0, plq_pkg::ST_OK, 0, 32'd0);
        add_row(plq_pkg::KIND_INSERT, 32'd0,         2, 1, 0, plq_pkg::ST_OK, 0, 32'd0);
        add_row(plq_pkg::KIND_SEARCH, 32'h8000_0000, 1, 1, 0, plq_pkg::ST_OK, 0, 32'd0);
        add_row(plq_pkg::KIND_SEARCH, 32'd0,         1, 1, 0, plq_pkg::ST_OK, 0, 32'd0);
        add_row(plq_pkg::KIND_SEARCH, 32'd12345,     1, 1, 0, plq_pkg::ST_OK, 0, 32'd0);
        add_row(plq_pkg::KIND_DELETE, 32'd0, 0,   1,   1, plq_pkg::ST_RANGE, 5, 32'hFFFF_FFFF);
        add_row(plq_pkg::KIND_DELETE, 32'd0, 6,   1,   1, plq_pkg::ST_RANGE, 5, 32'hFFFF_FFFF);
        add_row(plq_pkg::KIND_INSERT, 32'd9, 511, 511, 1, plq_pkg::ST_RANGE, 5, 32'hFFFF_FFFF);
        add_row(plq_pkg::KIND_DELETE, 32'd0, 2,   0,   1, plq_pkg::ST_OK,    5, 32'hFFFF_FFFF);
        add_row(plq_pkg::KIND_DELETE, 32'd0, 4,   511, 0, plq_pkg::ST_OK,    0, 32'd0);
        add_row(KIND_SPARE_LO,  32'hFFFF_FFFF, 511, 511, 0, plq_pkg::ST_OK, 0, 32'd0);
        add_row(KIND_SPARE_MID, 32'hFFFF_FFFF, 511, 511, 0, plq_pkg::ST_OK, 0, 32'd0);
        add_row(KIND_SPARE_HI,  32'hFFFF_FFFF, 511, 511, 0, plq_pkg::ST_OK, 0, 32'd0);
        add_row(plq_pkg::KIND_REMOVE, 32'd0, 1, 1, 0, plq_pkg::ST_OK,    0, 32'd0);
        add_row(plq_pkg::KIND_REMOVE, 32'd0, 1, 1, 0, plq_pkg::ST_OK,    0, 32'd0);
        add_row(plq_pkg::KIND_REMOVE, 32'd0, 1, 1, 0, plq_pkg::ST_OK,    0, 32'd0);
        add_row(plq_pkg::KIND_REMOVE, 32'd0, 1, 1, 1, plq_pkg::ST_EMPTY, 0, 32'd0);
        foreach (dir_rows[i])
            send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
        wait_all_results();

        for (phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 73 : (phase == 3) ? 14 : 0;
            recv_stall_pct = (phase == 2) ? 73 : (phase == 3) ? 14 : 0;
            if (phase == 2)
                hold_req = 1'b1;
            if (phase == 0)
            begin
                while (list_fill < plq_pkg::DEPTH)
                    send_plain(plq_pkg::KIND_APPEND, $urandom, 1, 1);
                send_plain(plq_pkg::KIND_APPEND, $urandom, 1, 1);
                send_plain(plq_pkg::KIND_INSERT, $urandom, 1, 1);
                send_plain(plq_pkg::KIND_INSERT, $urandom, 0, 1);
                send_plain(plq_pkg::KIND_INSERT, $urandom, 511, 1);
                send_plain(plq_pkg::KIND_SEARCH, list_entries[plq_pkg::DEPTH-1], 1, 1);
                send_plain(plq_pkg::KIND_DELETE, 32'd0, plq_pkg::DEPTH, 1);
                send_plain(plq_pkg::KIND_INSERT, 32'hFFFF_FFFF, plq_pkg::DEPTH, 1);
                send_plain(plq_pkg::KIND_DELETE, 32'd0, plq_pkg::DEPTH + 1, 1);
                send_plain(plq_pkg::KIND_DELETE, 32'd0, 1, 0);
                send_plain(plq_pkg::KIND_DELETE, 32'd0, 100, 511);
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (list_fill >= 200)
                    grow = 1'b0;
                else if (list_fill <= 8)
                    grow = 1'b1;
                r = pick_request(grow);
                send_plain(r.kind, r.value, r.pos, r.run);
            end
            wait_all_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_outcomes.size() != 0)
            report_mismatch("results never delivered", 32'(pending_outcomes.size()), 32'd0);
        $display("Checked %0d results: %0d appends, %0d removes, %0d inserts, %0d deletes,",
                 checked_count, kind_seen[plq_pkg::KIND_APPEND], kind_seen[plq_pkg::KIND_REMOVE],
                 kind_seen[plq_pkg::KIND_INSERT], kind_seen[plq_pkg::KIND_DELETE]);
        $display("%0d searches (%0d hits), %0d unused kinds, %0d full rejects, peak fill %0d.",
                 kind_seen[plq_pkg::KIND_SEARCH], found_seen,
                 kind_seen[KIND_SPARE_LO] + kind_seen[KIND_SPARE_MID] + kind_seen[KIND_SPARE_HI],
                 full_seen, peak_fill);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
